@@ sv/assert_macros.svh @@
// assertion helpers for the rtl
// each macro expects clk and rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define LTZ_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ltz: invariant violated");

// antecedent in one cycle implies consequent in the next
`define LTZ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ltz: sequence violated");

`endif

@@ sv/ltz_pkg.sv @@
`default_nettype none

package ltz_pkg;

    typedef struct packed {
        logic [15:0]        utc_year;
        logic [3:0]         utc_month;
        logic [4:0]         utc_day;
        logic [2:0]         utc_weekday;
        logic [4:0]         utc_hour;
        logic [5:0]         utc_minute;
        logic signed [15:0] zone_offset;
    } utc_word_t;

    typedef struct packed {
        logic [15:0]        local_year;
        logic [3:0]         local_month;
        logic [4:0]         local_day;
        logic [2:0]         local_weekday;
        logic [4:0]         local_hour;
        logic [5:0]         local_minute;
        logic signed [11:0] applied_offset;
    } local_word_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
    } date_t;

    localparam logic [10:0] MINUTES_PER_DAY  = 11'd1440;
    localparam logic [5:0]  MINUTES_PER_HOUR = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY    = 5'd24;
    localparam logic [6:0]  CENTURY          = 7'd100;
    localparam logic [2:0]  WDAY_LAST        = 3'd6;

    // reciprocal constants: floor(x / d) == (x * RECIP) >> SHIFT over the used range
    // day: (mag >> 5) / 45, x <= 1024
    localparam logic [10:0] DAY_RECIP        = 11'd1457;
    localparam int          DAY_RECIP_SHIFT  = 16;
    // hour: (sum >> 2) / 15, x <= 375
    localparam logic [9:0]  HOUR_RECIP       = 10'd547;
    localparam int          HOUR_RECIP_SHIFT = 13;
    // century: (year >> 2) / 25, x <= 16383
    localparam logic [13:0] CENT_RECIP       = 14'd10486;
    localparam int          CENT_RECIP_SHIFT = 18;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // month codes outside 1..12 count as 31 days
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month) inside
            MONTH_FEB:                                len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default:                                  len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] wday_next(input logic [2:0] w);
        logic [2:0] r;
        if (w == WDAY_LAST)
        begin
            r = 3'd0;
        end
        else if (w > WDAY_LAST)
        begin
            r = 3'd1;
        end
        else
        begin
            r = w + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [2:0] wday_prev(input logic [2:0] w);
        logic [2:0] r;
        if (w == 3'd0 || w > WDAY_LAST)
        begin
            r = WDAY_LAST;
        end
        else
        begin
            r = w - 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/ltz_stream_if.sv @@
`default_nettype none

interface ltz_stream_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/local_time_from_utc_offset.sv @@
// local time from a utc calendar time and a zone offset in minutes
//
// utc_time (sink) carries one utc word: year, month, day, weekday, hour,
// minute and a signed offset; local_time (source) returns one local word
// for each, in order, with the offset actually applied (reduced to +-1439
// by a remainder of 1440 that keeps the sign).
// both channels use valid/ready; a word moves when both are high.
// four register stages: offset reduction and century quotient, remainder
// and minute sum, hour split and neighbour dates, final select. each word
// passes through them in that order, and one word can be taken every
// cycle while local_time.ready stays high.
// each stage holds its own valid bit; a stall on local_time backs up only
// as far as the first empty stage, so utc_time.ready stays high while a
// bubble remains. nothing is dropped or repeated under stall.
// reset (rst_n low, asynchronous) empties the pipeline; there is no other
// state.
`default_nettype none

`include "assert_macros.svh"

module local_time_from_utc_offset import ltz_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ltz_stream_if.sink   utc_time,
    ltz_stream_if.source local_time
);

    // stage advance: a stage loads when it is empty or its contents move on
    logic s1_adv, s2_adv, s3_adv, s4_adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    assign s4_adv = !s4_valid_reg || local_time.ready;
    assign s3_adv = !s3_valid_reg || s4_adv;
    assign s2_adv = !s2_valid_reg || s3_adv;
    assign s1_adv = !s1_valid_reg || s2_adv;

    assign utc_time.ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= utc_time.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_adv)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: offset magnitude, quotient by 1440, quotient of year by 100
    // 1440 = 32 * 45, so the day quotient is (mag >> 5) / 45
    // ---------------------------------------------------------------
    utc_word_t   s1_word_reg;
    logic        s1_neg_reg;
    logic [15:0] s1_mag_reg;
    logic [4:0]  s1_dq_reg;
    logic [9:0]  s1_cq_reg;

    logic        s1_neg_next;
    logic [15:0] s1_mag_next;
    logic [21:0] s1_day_prod;
    logic [27:0] s1_cent_prod;

    assign s1_neg_next  = utc_time.data.zone_offset[15];
    // most negative offset gives 32768, still fits unsigned 16 bits
    assign s1_mag_next  = s1_neg_next ? 16'(~utc_time.data.zone_offset + 16'sd1)
                                      : 16'(utc_time.data.zone_offset);
    assign s1_day_prod  = 22'(s1_mag_next[15:5]) * 22'(DAY_RECIP);
    assign s1_cent_prod = 28'(utc_time.data.utc_year[15:2]) * 28'(CENT_RECIP);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_word_reg <= utc_time.data;
            s1_neg_reg  <= s1_neg_next;
            s1_mag_reg  <= s1_mag_next;
            s1_dq_reg   <= s1_day_prod[DAY_RECIP_SHIFT +: 5];
            s1_cq_reg   <= s1_cent_prod[CENT_RECIP_SHIFT +: 10];
        end
    end

    // ---------------------------------------------------------------
    // stage 2: remainder gives the applied offset, add it to the minute,
    // gregorian leap flag from the century quotient
    // ---------------------------------------------------------------
    date_t              s2_date_reg;
    logic [4:0]         s2_hour_reg;
    logic signed [11:0] s2_off_reg;
    logic signed [11:0] s2_sum_reg;
    logic               s2_leap_reg;

    logic [15:0]        s2_rem_wide;
    logic [10:0]        s2_rem;
    logic signed [11:0] s2_off_next;
    logic signed [11:0] s2_sum_next;
    logic               s2_div100;
    logic               s2_div400;
    logic               s2_leap_next;
    date_t              s2_date_next;

    assign s2_rem_wide = s1_mag_reg - 16'(16'(s1_dq_reg) * 16'(MINUTES_PER_DAY));
    assign s2_rem      = s2_rem_wide[10:0];
    // truncating remainder: sign follows the offset
    assign s2_off_next = s1_neg_reg ? -$signed({1'b0, s2_rem}) : $signed({1'b0, s2_rem});
    assign s2_sum_next = s2_off_next + $signed({6'b0, s1_word_reg.utc_minute});

    assign s2_div100    = (16'(16'(s1_cq_reg) * 16'(CENTURY)) == s1_word_reg.utc_year);
    assign s2_div400    = s2_div100 && (s1_cq_reg[1:0] == 2'b00);
    assign s2_leap_next = (s1_word_reg.utc_year[1:0] == 2'b00) && (!s2_div100 || s2_div400);

    assign s2_date_next.year  = s1_word_reg.utc_year;
    assign s2_date_next.month = s1_word_reg.utc_month;
    assign s2_date_next.day   = s1_word_reg.utc_day;
    assign s2_date_next.wday  = s1_word_reg.utc_weekday;

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_date_reg <= s2_date_next;
            s2_hour_reg <= s1_word_reg.utc_hour;
            s2_off_reg  <= s2_off_next;
            s2_sum_reg  <= s2_sum_next;
            s2_leap_reg <= s2_leap_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: fold a negative minute sum into the day before, hour
    // quotient of the sum (60 = 4 * 15), both neighbour dates
    // ---------------------------------------------------------------
    logic [10:0]        s3_adj_reg;
    logic [4:0]         s3_hq_reg;
    logic signed [6:0]  s3_hour_reg;
    logic signed [11:0] s3_off_reg;
    date_t              s3_cur_reg;
    date_t              s3_prev_reg;
    date_t              s3_next_reg;

    logic               s3_wrap;
    logic [10:0]        s3_adj_next;
    logic signed [6:0]  s3_hour_next;
    logic [18:0]        s3_hour_prod;
    date_t              s3_prev_next;
    date_t              s3_next_next;

    assign s3_wrap      = s2_sum_reg[11];
    assign s3_adj_next  = s3_wrap ? 11'(s2_sum_reg + $signed({1'b0, MINUTES_PER_DAY}))
                                  : 11'(s2_sum_reg);
    assign s3_hour_next = $signed({2'b00, s2_hour_reg})
                        - (s3_wrap ? $signed({2'b00, HOURS_PER_DAY}) : 7'sd0);
    assign s3_hour_prod = 19'(s3_adj_next[10:2]) * 19'(HOUR_RECIP);

    ltz_date_step u_date_step
    (
        .cur      (s2_date_reg),
        .leap     (s2_leap_reg),
        .prev_day (s3_prev_next),
        .next_day (s3_next_next)
    );

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_adj_reg  <= s3_adj_next;
            s3_hq_reg   <= s3_hour_prod[HOUR_RECIP_SHIFT +: 5];
            s3_hour_reg <= s3_hour_next;
            s3_off_reg  <= s2_off_reg;
            s3_cur_reg  <= s2_date_reg;
            s3_prev_reg <= s3_prev_next;
            s3_next_reg <= s3_next_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: minute remainder, final hour, pick the date by crossing
    // ---------------------------------------------------------------
    local_word_t       s4_word_reg;

    logic [10:0]       s4_min_wide;
    logic signed [6:0] s4_hour_sum;
    logic signed [6:0] s4_hour_fix;
    logic              s4_back;
    logic              s4_fwd;
    date_t             s4_date;
    local_word_t       s4_word_next;

    assign s4_min_wide = s3_adj_reg - 11'(11'(s3_hq_reg) * 11'(MINUTES_PER_HOUR));
    assign s4_hour_sum = s3_hour_reg + $signed({2'b00, s3_hq_reg});
    assign s4_back     = s4_hour_sum < 7'sd0;
    assign s4_fwd      = s4_hour_sum > $signed({2'b00, HOURS_PER_DAY - 5'd1});

    always_comb
    begin
        s4_hour_fix = s4_hour_sum;
        s4_date     = s3_cur_reg;
        if (s4_back)
        begin
            s4_hour_fix = s4_hour_sum + $signed({2'b00, HOURS_PER_DAY});
            s4_date     = s3_prev_reg;
        end
        else if (s4_fwd)
        begin
            s4_hour_fix = s4_hour_sum - $signed({2'b00, HOURS_PER_DAY});
            s4_date     = s3_next_reg;
        end
    end

    assign s4_word_next.local_year     = s4_date.year;
    assign s4_word_next.local_month    = s4_date.month;
    assign s4_word_next.local_day      = s4_date.day;
    assign s4_word_next.local_weekday  = s4_date.wday;
    assign s4_word_next.local_hour     = s4_hour_fix[4:0];
    assign s4_word_next.local_minute   = s4_min_wide[5:0];
    assign s4_word_next.applied_offset = s3_off_reg;

    always_ff @(posedge clk)
    begin
        if (s4_adv)
        begin
            s4_word_reg <= s4_word_next;
        end
    end

    assign local_time.valid = s4_valid_reg;
    assign local_time.data  = s4_word_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `LTZ_ASSERT_HOLDS(a_offset_reduced, !s2_valid_reg || (s2_off_reg <= 12'sd1439 && s2_off_reg >= -12'sd1439))
    `LTZ_ASSERT_HOLDS(a_minute_sum_range, !s3_valid_reg || s3_adj_reg <= 11'd1502)
    `LTZ_ASSERT_HOLDS(a_hour_quot_range, !s3_valid_reg || s3_hq_reg <= 5'd25)
    `LTZ_ASSERT_HOLDS(a_minute_range, !s4_valid_reg || s4_word_reg.local_minute <= 6'd59)
    `LTZ_ASSERT_NEXT(a_stage3_held, s3_valid_reg && !s3_adv, s3_valid_reg)

endmodule

`default_nettype wire

@@ sv/ltz_date_step.sv @@
`default_nettype none

// neighbouring calendar dates one day back and one day forward
module ltz_date_step import ltz_pkg::*;
(
    input  date_t cur,
    input  logic  leap,
    output date_t prev_day,
    output date_t next_day
);

    always_comb
    begin
        prev_day.wday  = wday_prev(cur.wday);
        prev_day.year  = cur.year;
        prev_day.month = cur.month;
        prev_day.day   = cur.day - 5'd1;
        if (cur.day <= 5'd1)
        begin
            if (cur.month <= MONTH_JAN)
            begin
                prev_day.month = MONTH_DEC;
                prev_day.year  = cur.year - 16'd1;
            end
            else
            begin
                prev_day.month = cur.month - 4'd1;
            end
            // leap flag of the current year is right: only december changes year
            prev_day.day = month_days(prev_day.month, leap);
        end
    end

    always_comb
    begin
        next_day.wday  = wday_next(cur.wday);
        next_day.year  = cur.year;
        next_day.month = cur.month;
        next_day.day   = cur.day + 5'd1;
        if (cur.day >= month_days(cur.month, leap))
        begin
            next_day.day = 5'd1;
            if (cur.month >= MONTH_DEC)
            begin
                next_day.month = MONTH_JAN;
                next_day.year  = cur.year + 16'd1;
            end
            else
            begin
                next_day.month = cur.month + 4'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_local_time_from_utc_offset.sv @@
`default_nettype none

module tb_local_time_from_utc_offset;
    timeunit 1ns;
    timeprecision 1ps;

    import ltz_pkg::*;

    // calendar constants for the local time predictor
    localparam int DAY_MINUTES  = 1440;
    localparam int HOUR_MINUTES = 60;
    localparam int DAY_HOURS    = 24;
    localparam int LAST_HOUR    = 23;
    localparam int LAST_MINUTE  = 59;
    localparam int WEEK_DAYS    = 7;

    // run shape
    localparam int RANDOM_WORDS   = 625;
    localparam int RANDOM_CHUNKS  = 4;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_AFTER = 120;

    // receiver stall patterns
    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_RANDOM,
        SINK_TOGGLE,
        SINK_HOLD_OFF
    } sink_mode_t;

    logic clk;
    logic rst_n;

    ltz_stream_if #(.word_t(utc_word_t))   utc_bus ();
    ltz_stream_if #(.word_t(local_word_t)) local_bus ();

    local_time_from_utc_offset dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .utc_time   (utc_bus),
        .local_time (local_bus)
    );

    // utc words waiting to be offered, and local words the block owes us
    utc_word_t   utc_backlog[$];
    local_word_t owed_local_words[$];

    int mismatch_count;
    int words_taken;
    int idle_cycles;

    // ------------------------------------------------------------------
    // local time predictor
    // ------------------------------------------------------------------

    // gregorian month length; a month code outside january..december
    // counts as 31 days
    function automatic int days_in_month(int unsigned yr, int mon);
        if (mon < int'(MONTH_JAN) || mon > int'(MONTH_DEC))
        begin
            return 31;
        end
        if (mon == int'(MONTH_FEB))
        begin
            if (yr % 4 != 0)
            begin
                return 28;
            end
            if (yr % 100 != 0)
            begin
                return 29;
            end
            return (yr % 400 != 0) ? 28 : 29;
        end
        if (mon == int'(MONTH_APR) || mon == int'(MONTH_JUN) ||
            mon == int'(MONTH_SEP) || mon == int'(MONTH_NOV))
        begin
            return 30;
        end
        return 31;
    endfunction

    function automatic local_word_t predict_local_time(utc_word_t w);
        int unsigned yr;
        int          mon;
        int          dd;
        int          wd;
        int          hh;
        int          mm;
        int          off;
        local_word_t r;
        yr  = w.utc_year;
        mon = w.utc_month;
        dd  = w.utc_day;
        wd  = w.utc_weekday;
        hh  = w.utc_hour;
        mm  = w.utc_minute;
        off = $signed(w.zone_offset);

        // truncating remainder keeps the sign of the offset
        if (off <= -DAY_MINUTES || off >= DAY_MINUTES)
        begin
            off = off % DAY_MINUTES;
        end

        mm = mm + off;
        if (mm < 0)
        begin
            mm = mm + DAY_MINUTES;
            hh = hh - DAY_HOURS;
        end
        hh = hh + mm / HOUR_MINUTES;
        mm = mm % HOUR_MINUTES;

        if (hh < 0)
        begin
            // back over midnight
            hh = hh + DAY_HOURS;
            wd = (wd + WEEK_DAYS - 1) % WEEK_DAYS;
            dd = dd - 1;
            if (dd < 1)
            begin
                mon = mon - 1;
                if (mon < int'(MONTH_JAN))
                begin
                    mon = int'(MONTH_DEC);
                    yr  = (yr - 1) & 32'hFFFF;
                end
                dd = days_in_month(yr, mon);
            end
        end
        else if (hh > LAST_HOUR)
        begin
            // forward over midnight
            hh = hh - DAY_HOURS;
            wd = (wd + 1) % WEEK_DAYS;
            dd = dd + 1;
            if (dd > days_in_month(yr, mon))
            begin
                dd  = 1;
                mon = mon + 1;
                if (mon > int'(MONTH_DEC))
                begin
                    mon = int'(MONTH_JAN);
                    yr  = (yr + 1) & 32'hFFFF;
                end
            end
        end

        r.local_year     = yr[15:0];
        r.local_month    = mon[3:0];
        r.local_day      = dd[4:0];
        r.local_weekday  = wd[2:0];
        r.local_hour     = hh[4:0];
        r.local_minute   = mm[5:0];
        r.applied_offset = off[11:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic utc_word_t make_utc(int yr, int mon, int dd, int wd,
                                           int hh, int mm, int off);
        utc_word_t w;
        w.utc_year    = 16'(yr);
        w.utc_month   = 4'(mon);
        w.utc_day     = 5'(dd);
        w.utc_weekday = 3'(wd);
        w.utc_hour    = 5'(hh);
        w.utc_minute  = 6'(mm);
        w.zone_offset = 16'(off);
        return w;
    endfunction

    // mostly well-formed calendar times pushed towards the day, month and
    // year edges, a share with one field broken, and a share of pure noise
    function automatic utc_word_t random_utc_word();
        utc_word_t w;
        int        kind;
        int        yr;
        int        mon;
        int        len;
        int        dd;
        int        hh;
        int        mm;
        int        off;
        kind = $urandom_range(0, 9);
        if (kind >= 8)
        begin
            w = make_utc($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            return w;
        end

        case ($urandom_range(0, 4))
            0:       yr = $urandom_range(0, 65535);
            1:       yr = 400 * $urandom_range(0, 163);
            2:       yr = 100 * $urandom_range(0, 655);
            3:       yr = 4 * $urandom_range(0, 16383);
            default: yr = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : 65535 - $urandom_range(0, 3);
        endcase
        mon = $urandom_range(int'(MONTH_JAN), int'(MONTH_DEC));
        if ($urandom_range(0, 3) == 0)
        begin
            mon = int'(MONTH_FEB);
        end
        len = days_in_month(yr, mon);
        case ($urandom_range(0, 2))
            0:       dd = 1;
            1:       dd = len;
            default: dd = $urandom_range(1, len);
        endcase
        case ($urandom_range(0, 2))
            0:       hh = 0;
            1:       hh = LAST_HOUR;
            default: hh = $urandom_range(0, LAST_HOUR);
        endcase
        case ($urandom_range(0, 2))
            0:       mm = 0;
            1:       mm = LAST_MINUTE;
            default: mm = $urandom_range(0, LAST_MINUTE);
        endcase
        case ($urandom_range(0, 4))
            0:       off = $urandom_range(0, 2 * (DAY_MINUTES - 1)) - (DAY_MINUTES - 1);
            1:       off = $urandom_range(0, 65535) - 32768;
            2:       off = $urandom_range(0, 240) - 120;
            3:       off = DAY_MINUTES * ($urandom_range(0, 44) - 22)
                           + $urandom_range(0, 4) - 2;
            default: off = $urandom_range(0, 1) ? DAY_MINUTES - 1 : 1 - DAY_MINUTES;
        endcase
        w = make_utc(yr, mon, dd, $urandom_range(0, WEEK_DAYS - 1), hh, mm, off);

        // broken word: one field out of its legal range (the day may also land on the month's last day)
        if (kind == 7)
        begin
            case ($urandom_range(0, 4))
                0:       w.utc_month   = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
                1:       w.utc_day     = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(len, 31));
                2:       w.utc_weekday = 3'd7;
                3:       w.utc_hour    = 5'($urandom_range(DAY_HOURS, 31));
                default: w.utc_minute  = 6'($urandom_range(HOUR_MINUTES, 63));
            endcase
        end
        return w;
    endfunction

    // sender pause: nothing more is offered until every owed word is back
    task automatic drain_all();
        while (utc_backlog.size() != 0 || utc_bus.valid)
        begin
            @(negedge clk);
        end
        while (owed_local_words.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic report_field(string name, int expected_val, int actual_val);
        $display("%0t: local word %s mismatch: expected %0d, got %0d",
                 $time, name, expected_val, actual_val);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // reset held low at the start; the driver and receiver clear their own
    // outputs while it is low
    initial
    begin
        rst_n = 1'b0;
        repeat (7)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // driver: offers backlog words in bursts with random gaps
    // ------------------------------------------------------------------

    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utc_bus.valid <= 1'b0;
            utc_bus.data  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin : drive_step
            logic      next_valid;
            utc_word_t next_data;
            int        nb;
            int        ng;
            next_valid = utc_bus.valid;
            next_data  = utc_bus.data;
            nb         = burst_left;
            ng         = gap_left;
            // a word on offer stays put until it is taken
            if (!utc_bus.valid || utc_bus.ready)
            begin
                next_valid = 1'b0;
                if (ng > 0)
                begin
                    ng = ng - 1;
                end
                else if (utc_backlog.size() != 0)
                begin
                    next_valid = 1'b1;
                    next_data  = utc_backlog.pop_front();
                    if (nb <= 1)
                    begin
                        // new burst; about half the time no gap at all
                        nb = $urandom_range(1, 24);
                        ng = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        nb = nb - 1;
                    end
                end
            end
            utc_bus.valid <= next_valid;
            utc_bus.data  <= next_data;
            burst_left    <= nb;
            gap_left      <= ng;
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready follows a pattern of segments, one of them a long
    // hold-off that fills the pipeline and backs up the input
    // ------------------------------------------------------------------

    sink_mode_t sink_mode;
    int         sink_left;
    logic       hold_off_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_bus.ready <= 1'b0;
            sink_mode       <= SINK_FREE;
            sink_left       <= 0;
            hold_off_done   <= 1'b0;
        end
        else
        begin : sink_step
            sink_mode_t mode;
            int         left;
            logic       held;
            logic       rdy;
            mode = sink_mode;
            left = sink_left;
            held = hold_off_done;
            if (left == 0)
            begin
                if (!held && words_taken >= HOLD_OFF_AFTER)
                begin
                    mode = SINK_HOLD_OFF;
                end
                else
                begin
                    case ($urandom_range(0, 11))
                        0:                mode = SINK_HOLD_OFF;
                        1, 2, 3, 4:       mode = SINK_RANDOM;
                        5, 6:             mode = SINK_TOGGLE;
                        default:          mode = SINK_FREE;
                    endcase
                end
                if (mode == SINK_HOLD_OFF)
                begin
                    held = 1'b1;
                    left = $urandom_range(60, 90);
                end
                else
                begin
                    left = $urandom_range(8, 40);
                end
            end
            else
            begin
                left = left - 1;
            end
            case (mode)
                SINK_RANDOM:   rdy = ($urandom_range(0, 2) != 0);
                SINK_TOGGLE:   rdy = !local_bus.ready;
                SINK_HOLD_OFF: rdy = 1'b0;
                default:       rdy = 1'b1;
            endcase
            local_bus.ready <= rdy;
            sink_mode       <= mode;
            sink_left       <= left;
            hold_off_done   <= held;
        end
    end

    // ------------------------------------------------------------------
    // monitor: results checked before the new expectation is queued, so
    // the order within one edge never matters
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (local_bus.valid && local_bus.ready)
            begin : check_word
                local_word_t owed;
                local_word_t seen;
                seen = local_bus.data;
                if (owed_local_words.size() == 0)
                begin
                    $display("%0t: local word with none owed: got %p", $time, seen);
                    mismatch_count++;
                end
                else
                begin
                    owed = owed_local_words.pop_front();
                    if (seen.local_year !== owed.local_year)
                        report_field("year", owed.local_year, seen.local_year);
                    if (seen.local_month !== owed.local_month)
                        report_field("month", owed.local_month, seen.local_month);
                    if (seen.local_day !== owed.local_day)
                        report_field("day", owed.local_day, seen.local_day);
                    if (seen.local_weekday !== owed.local_weekday)
                        report_field("weekday", owed.local_weekday, seen.local_weekday);
                    if (seen.local_hour !== owed.local_hour)
                        report_field("hour", owed.local_hour, seen.local_hour);
                    if (seen.local_minute !== owed.local_minute)
                        report_field("minute", owed.local_minute, seen.local_minute);
                    if (seen.applied_offset !== owed.applied_offset)
                        report_field("applied offset", owed.applied_offset,
                                     seen.applied_offset);
                end
            end
            if (utc_bus.valid && utc_bus.ready)
            begin
                owed_local_words.push_back(predict_local_time(utc_bus.data));
                words_taken <= words_taken + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no word moving on either side
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((utc_bus.valid && utc_bus.ready) || (local_bus.valid && local_bus.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------

    initial
    begin
        @(negedge clk);
        while (rst_n !== 1'b1)
        begin
            @(negedge clk);
        end

        // year wrap both ways
        utc_backlog.push_back(make_utc(0, 1, 1, 0, 0, 0, -1));
        utc_backlog.push_back(make_utc(65535, 12, 31, 6, 23, 59, 1));
        // offset extremes and the reduction edges
        utc_backlog.push_back(make_utc(2023, 6, 15, 4, 12, 30, -32768));
        utc_backlog.push_back(make_utc(2023, 6, 15, 4, 12, 30, 32767));
        utc_backlog.push_back(make_utc(2023, 6, 15, 4, 23, 59, 1439));
        utc_backlog.push_back(make_utc(2023, 6, 15, 4, 0, 0, -1439));
        utc_backlog.push_back(make_utc(2023, 6, 15, 4, 7, 45, 1440));
        utc_backlog.push_back(make_utc(2023, 6, 15, 4, 7, 45, -1440));
        // every calendar field at all ones, and all zeros, both with no offset
        utc_backlog.push_back(make_utc(65535, 15, 31, 7, 31, 63, 0));
        utc_backlog.push_back(make_utc(0, 0, 0, 0, 0, 0, 0));
        // weekday code 7 forward and back
        utc_backlog.push_back(make_utc(2022, 3, 10, 7, 23, 30, 60));
        utc_backlog.push_back(make_utc(2022, 3, 10, 7, 0, 10, -30));
        // month code 0 stepping back, month codes above december stepping on
        utc_backlog.push_back(make_utc(1999, 0, 1, 3, 0, 0, -1));
        utc_backlog.push_back(make_utc(1999, 13, 31, 3, 23, 59, 1));
        utc_backlog.push_back(make_utc(65535, 15, 31, 3, 23, 0, 90));
        // day 0 back, day past the month end forward
        utc_backlog.push_back(make_utc(2010, 5, 0, 2, 1, 0, -120));
        utc_backlog.push_back(make_utc(2010, 4, 31, 2, 22, 0, 180));
        // february under the leap rules
        utc_backlog.push_back(make_utc(2000, 2, 28, 1, 23, 59, 1));
        utc_backlog.push_back(make_utc(2000, 2, 29, 2, 23, 59, 1));
        utc_backlog.push_back(make_utc(1900, 2, 28, 3, 23, 0, 60));
        utc_backlog.push_back(make_utc(2024, 3, 1, 5, 0, 0, -1));
        utc_backlog.push_back(make_utc(2100, 3, 1, 1, 0, 30, -31));
        // hour and minute out of range
        utc_backlog.push_back(make_utc(2015, 8, 20, 4, 31, 0, -1000));
        utc_backlog.push_back(make_utc(2015, 8, 20, 4, 0, 63, -100));
        // new year from a later offset
        utc_backlog.push_back(make_utc(2024, 12, 31, 2, 20, 0, 300));
        drain_all();

        // random part in chunks, the sender pausing for a full drain
        // between them
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            repeat (RANDOM_WORDS / RANDOM_CHUNKS)
            begin
                utc_backlog.push_back(random_utc_word());
            end
            drain_all();
        end

        // let anything stray show up before the verdict
        repeat (SETTLE_CYCLES)
        begin
            @(negedge clk);
        end
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/ltz_pkg.sv
sv/ltz_stream_if.sv
sv/ltz_date_step.sv
sv/local_time_from_utc_offset.sv
tb/tb_local_time_from_utc_offset.sv
